// ----- hw/rtl/cdiv_pkg.sv -----
// cdiv_pkg: shared widths, word types and stage control struct for the complex divider.
// Used by every module under hw/rtl; depends on nothing.
package cdiv_pkg;

  localparam int DATA_WIDTH    = 16;
  localparam int FRAC_BITS_DEF = 8;

  // input word: dividend and divisor, signed fixed point
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] a_re;
    logic signed [DATA_WIDTH-1:0] a_im;
    logic signed [DATA_WIDTH-1:0] b_re;
    logic signed [DATA_WIDTH-1:0] b_im;
  } cdiv_in_t;

  // result word
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] q_re;
    logic signed [DATA_WIDTH-1:0] q_im;
    logic                         div_by_zero;
    logic                         saturated;
  } cdiv_out_t;

  // control that travels with each word through the divide stages
  typedef struct packed {
    logic valid;
    logic dz;
    logic neg_re;
    logic neg_im;
    logic ovf_re;
    logic ovf_im;
  } cdiv_ctl_t;

endpackage

// ----- hw/rtl/complex_divider.sv -----
// complex_divider: top level - front stages, DATA_WIDTH+1 divide stages, output register.
// Depends on cdiv_pkg, cdiv_front, cdiv_step.
//
// Usage:
//   Input channel in_valid / in_stall / in_data carries one word: dividend a and
//   divisor b, signed fixed point with FRAC_BITS fraction bits. Output channel
//   out_valid / out_stall / out_data returns the quotient a / b, truncated toward
//   zero and clipped to range, with saturated and div_by_zero flags. A zero
//   divisor returns zero with div_by_zero set.
//   Throughput: one word per cycle while out_stall is low.
//   Pipeline from acceptance to out_valid: three front stages (products, sums,
//   magnitudes), one restoring-divide stage per quotient bit (DATA_WIDTH + 1
//   of them), and the output register.
//   Stall: while out_valid and out_stall are both high the whole pipeline holds
//   and in_stall is raised in the same cycle; nothing is dropped or repeated.
//   Reset (rst_n low, synchronous) clears every stage's valid bit; data in
//   flight is discarded.
module complex_divider import cdiv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  cdiv_in_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output cdiv_out_t out_data
);

  localparam int W     = DATA_WIDTH;
  localparam int NW    = 2 * W + FRAC_BITS;
  localparam int QW    = W + 1;
  localparam int NSTEP = W + 1;

  logic out_valid_r;
  logic adv;
  assign adv      = ~out_valid_r | ~out_stall;
  assign in_stall = ~adv;

  cdiv_ctl_t      ctl_s    [NSTEP+1];
  logic [NW-1:0]  rem_re_s [NSTEP+1];
  logic [NW-1:0]  rem_im_s [NSTEP+1];
  logic [QW-1:0]  q_re_s   [NSTEP+1];
  logic [QW-1:0]  q_im_s   [NSTEP+1];
  logic [2*W-1:0] den_s    [NSTEP+1];

  cdiv_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .adv      (adv),
    .in_valid (in_valid),
    .in_data  (in_data),
    .ctl_o    (ctl_s[0]),
    .rem_re_o (rem_re_s[0]),
    .rem_im_o (rem_im_s[0]),
    .den_o    (den_s[0])
  );

  assign q_re_s[0] = '0;
  assign q_im_s[0] = '0;

  // most significant quotient bit first
  for (genvar i = 0; i < NSTEP; i++) begin : g_step
    cdiv_step #(.FRAC_BITS(FRAC_BITS), .BIT(W - i)) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .ctl_i    (ctl_s[i]),
      .rem_re_i (rem_re_s[i]),
      .rem_im_i (rem_im_s[i]),
      .q_re_i   (q_re_s[i]),
      .q_im_i   (q_im_s[i]),
      .den_i    (den_s[i]),
      .ctl_o    (ctl_s[i+1]),
      .rem_re_o (rem_re_s[i+1]),
      .rem_im_o (rem_im_s[i+1]),
      .q_re_o   (q_re_s[i+1]),
      .q_im_o   (q_im_s[i+1]),
      .den_o    (den_s[i+1])
    );
  end

  // clip, restore sign, force zero on a zero divisor
  cdiv_ctl_t     ctl_f;
  logic [QW-1:0] q_re_f, q_im_f, lim_re, lim_im, qc_re, qc_im, qn_re, qn_im;
  logic [QW-1:0] lim_pos;
  logic          over_re, over_im;
  cdiv_out_t     out_nxt, out_data_r;

  assign ctl_f   = ctl_s[NSTEP];
  assign q_re_f  = q_re_s[NSTEP];
  assign q_im_f  = q_im_s[NSTEP];
  assign lim_pos = (QW'(1) << (W - 1)) - QW'(1);
  assign lim_re  = ctl_f.neg_re ? (QW'(1) << (W - 1)) : lim_pos;
  assign lim_im  = ctl_f.neg_im ? (QW'(1) << (W - 1)) : lim_pos;
  assign over_re = ctl_f.ovf_re | (q_re_f > lim_re);
  assign over_im = ctl_f.ovf_im | (q_im_f > lim_im);
  assign qc_re   = over_re ? lim_re : q_re_f;
  assign qc_im   = over_im ? lim_im : q_im_f;
  assign qn_re   = ctl_f.neg_re ? (QW'(0) - qc_re) : qc_re;
  assign qn_im   = ctl_f.neg_im ? (QW'(0) - qc_im) : qc_im;

  always_comb begin
    out_nxt = '0;
    if (ctl_f.dz) begin
      out_nxt.div_by_zero = 1'b1;
    end else begin
      out_nxt.q_re      = qn_re[W-1:0];
      out_nxt.q_im      = qn_im[W-1:0];
      out_nxt.saturated = over_re | over_im;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= ctl_f.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hw/rtl/cdiv_front.sv -----
// cdiv_front: three register stages - products, numerator/denominator sums,
// magnitudes with early overflow check. Depends on cdiv_pkg.
module cdiv_front import cdiv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                adv,
  input  logic                                in_valid,
  input  cdiv_in_t                            in_data,
  output cdiv_ctl_t                           ctl_o,
  output logic [2*DATA_WIDTH+FRAC_BITS-1:0]   rem_re_o,
  output logic [2*DATA_WIDTH+FRAC_BITS-1:0]   rem_im_o,
  output logic [2*DATA_WIDTH-1:0]             den_o
);

  localparam int W  = DATA_WIDTH;
  localparam int PW = 2 * W;
  localparam int NW = PW + FRAC_BITS;
  localparam int CW = 3 * W + FRAC_BITS + 1;

  // stage 1: products
  logic                 v1_r;
  logic signed [PW-1:0] p_rebr_r, p_imbi_r, p_imbr_r, p_rebi_r, p_brbr_r, p_bibi_r;
  logic signed [PW-1:0] ar_x, ai_x, br_x, bi_x;

  assign ar_x = PW'(in_data.a_re);
  assign ai_x = PW'(in_data.a_im);
  assign br_x = PW'(in_data.b_re);
  assign bi_x = PW'(in_data.b_im);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (adv) begin
      v1_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_rebr_r <= ar_x * br_x;
      p_imbi_r <= ai_x * bi_x;
      p_imbr_r <= ai_x * br_x;
      p_rebi_r <= ar_x * bi_x;
      p_brbr_r <= br_x * br_x;
      p_bibi_r <= bi_x * bi_x;
    end
  end

  // stage 2: a * conj(b) and |b|^2
  logic                 v2_r;
  logic signed [PW:0]   nre_r, nim_r;
  logic        [PW-1:0] den2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (adv) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nre_r  <= (PW+1)'(p_rebr_r) + (PW+1)'(p_imbi_r);
      nim_r  <= (PW+1)'(p_imbr_r) - (PW+1)'(p_rebi_r);
      den2_r <= $unsigned(p_brbr_r) + $unsigned(p_bibi_r);
    end
  end

  // stage 3: magnitudes, scale by the fraction, flag quotients past W+1 bits
  logic [PW:0]   neg_re_x, neg_im_x;
  logic [PW-1:0] mag_re, mag_im;
  logic [NW-1:0] num_re, num_im;
  logic [CW-1:0] den_top;
  cdiv_ctl_t     ctl_nxt, ctl_r;
  logic [NW-1:0] rem_re_r, rem_im_r;
  logic [PW-1:0] den_r;

  assign neg_re_x = (PW+1)'(0) - $unsigned(nre_r);
  assign neg_im_x = (PW+1)'(0) - $unsigned(nim_r);
  assign mag_re   = nre_r[PW] ? neg_re_x[PW-1:0] : nre_r[PW-1:0];
  assign mag_im   = nim_r[PW] ? neg_im_x[PW-1:0] : nim_r[PW-1:0];
  assign num_re   = NW'(mag_re) << FRAC_BITS;
  assign num_im   = NW'(mag_im) << FRAC_BITS;
  assign den_top  = CW'(den2_r) << (W + 1);

  always_comb begin
    ctl_nxt        = '0;
    ctl_nxt.valid  = v2_r;
    ctl_nxt.dz     = (den2_r == '0);
    ctl_nxt.neg_re = nre_r[PW];
    ctl_nxt.neg_im = nim_r[PW];
    ctl_nxt.ovf_re = (CW'(num_re) >= den_top);
    ctl_nxt.ovf_im = (CW'(num_im) >= den_top);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_re_r <= num_re;
      rem_im_r <= num_im;
      den_r    <= den2_r;
    end
  end

  assign ctl_o    = ctl_r;
  assign rem_re_o = rem_re_r;
  assign rem_im_o = rem_im_r;
  assign den_o    = den_r;

endmodule

// ----- hw/rtl/cdiv_step.sv -----
// cdiv_step: one restoring-division stage, settles quotient bit BIT of both parts.
// Depends on cdiv_pkg.
module cdiv_step import cdiv_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int BIT       = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              adv,
  input  cdiv_ctl_t                         ctl_i,
  input  logic [2*DATA_WIDTH+FRAC_BITS-1:0] rem_re_i,
  input  logic [2*DATA_WIDTH+FRAC_BITS-1:0] rem_im_i,
  input  logic [DATA_WIDTH:0]               q_re_i,
  input  logic [DATA_WIDTH:0]               q_im_i,
  input  logic [2*DATA_WIDTH-1:0]           den_i,
  output cdiv_ctl_t                         ctl_o,
  output logic [2*DATA_WIDTH+FRAC_BITS-1:0] rem_re_o,
  output logic [2*DATA_WIDTH+FRAC_BITS-1:0] rem_im_o,
  output logic [DATA_WIDTH:0]               q_re_o,
  output logic [DATA_WIDTH:0]               q_im_o,
  output logic [2*DATA_WIDTH-1:0]           den_o
);

  localparam int W  = DATA_WIDTH;
  localparam int NW = 2 * W + FRAC_BITS;
  localparam int QW = W + 1;
  localparam int CW = 3 * W + FRAC_BITS + 1;

  logic [CW-1:0] den_sh, diff_re, diff_im;
  logic          take_re, take_im;
  logic [QW-1:0] qbit;

  assign den_sh  = CW'(den_i) << BIT;
  assign take_re = (CW'(rem_re_i) >= den_sh);
  assign take_im = (CW'(rem_im_i) >= den_sh);
  assign diff_re = CW'(rem_re_i) - den_sh;
  assign diff_im = CW'(rem_im_i) - den_sh;
  assign qbit    = QW'(1) << BIT;

  cdiv_ctl_t     ctl_r;
  logic [NW-1:0] rem_re_r, rem_im_r;
  logic [QW-1:0] q_re_r, q_im_r;
  logic [2*W-1:0] den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r <= '0;
    end else if (adv) begin
      ctl_r <= ctl_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rem_re_r <= take_re ? diff_re[NW-1:0] : rem_re_i;
      rem_im_r <= take_im ? diff_im[NW-1:0] : rem_im_i;
      q_re_r   <= take_re ? (q_re_i | qbit) : q_re_i;
      q_im_r   <= take_im ? (q_im_i | qbit) : q_im_i;
      den_r    <= den_i;
    end
  end

  assign ctl_o    = ctl_r;
  assign rem_re_o = rem_re_r;
  assign rem_im_o = rem_im_r;
  assign q_re_o   = q_re_r;
  assign q_im_o   = q_im_r;
  assign den_o    = den_r;

endmodule

// ----- hw/rtl/cdiv_checker.sv -----
// cdiv_checker: port-level assertions for complex_divider, bound to the top level.
// Depends on cdiv_pkg and complex_divider.
module cdiv_checker import cdiv_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input cdiv_in_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input cdiv_out_t out_data
);

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) (rst_n && $past(!rst_n)) |-> !out_valid)
    else $error("out_valid high right after reset");

  // input is held back only by a blocked result word
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("in_stall without a blocked output word");

  // a stalled input word stays put
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_data)))
    else $error("stalled input word changed or dropped");

  // a blocked result word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled output word changed or dropped");

  // zero divisor gives a zero quotient and no clip flag
  a_dz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.div_by_zero) |->
      (out_data.q_re == '0 && out_data.q_im == '0 && !out_data.saturated))
    else $error("div_by_zero word with nonzero quotient or saturated");

endmodule

bind complex_divider cdiv_checker u_cdiv_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- dv/tb.sv -----
// tb: self-checking testbench for complex_divider, Q8.8 complex division with saturation.
// Drives input words with random idling, predicts each quotient in integer math and
// checks every result word in order; depends on cdiv_pkg and complex_divider.
module tb;
  import cdiv_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = DATA_WIDTH + 5;
  localparam int CYCLE_LIMIT = 200000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  cdiv_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  cdiv_out_t out_data;

  cdiv_out_t quot_expected[$];
  bit        idle_on = 1'b1;
  int        errors = 0;
  int        n_sent = 0;
  int        n_checked = 0;
  int        n_zero_div = 0;
  int        n_clipped = 0;
  int        cycles = 0;

  complex_divider u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, quot_expected.size());
      $display("tb: errors");
      $finish;
    end
  end

  // Scaled magnitude divide: {clipped, quotient} of num * 2^FRAC / den, toward zero.
  function automatic logic [DATA_WIDTH:0] scaled_div(longint num, longint den);
    longint mag;
    longint q;
    longint lim;
    bit     clip;
    mag = (num < 0) ? -num : num;
    q = (mag << FRAC_BITS_DEF) / den;
    lim = (longint'(1) << (DATA_WIDTH - 1)) - ((num < 0) ? 0 : 1);
    clip = (q > lim);
    if (clip) q = lim;
    if (num < 0) q = -q;
    return {clip, q[DATA_WIDTH-1:0]};
  endfunction

  function automatic cdiv_out_t quotient_of(cdiv_in_t w);
    cdiv_out_t r;
    longint ar, ai, br, bi, den, n_re, n_im;
    logic [DATA_WIDTH:0] part;
    ar = $signed(w.a_re);
    ai = $signed(w.a_im);
    br = $signed(w.b_re);
    bi = $signed(w.b_im);
    r = '0;
    den = br * br + bi * bi;
    if (den == 0) begin
      r.div_by_zero = 1'b1;
      return r;
    end
    // multiply by the conjugate of the divisor
    n_re = ar * br + ai * bi;
    n_im = ai * br - ar * bi;
    part = scaled_div(n_re, den);
    r.q_re = part[DATA_WIDTH-1:0];
    r.saturated = part[DATA_WIDTH];
    part = scaled_div(n_im, den);
    r.q_im = part[DATA_WIDTH-1:0];
    r.saturated = r.saturated | part[DATA_WIDTH];
    return r;
  endfunction

  function automatic cdiv_in_t pack_word(int ar, int ai, int br, int bi);
    cdiv_in_t w;
    w.a_re = ar[DATA_WIDTH-1:0];
    w.a_im = ai[DATA_WIDTH-1:0];
    w.b_re = br[DATA_WIDTH-1:0];
    w.b_im = bi[DATA_WIDTH-1:0];
    return w;
  endfunction

  // 0: full range, 1: near zero, 2: range edges and unit values
  function automatic logic [DATA_WIDTH-1:0] pick_part(int unsigned style);
    int v;
    case (style)
      0: v = int'($urandom_range(65535));
      1: v = int'($urandom_range(8)) - 4;
      default: begin
        case ($urandom_range(5))
          0: v = -32768;
          1: v = -32767;
          2: v = -1;
          3: v = 0;
          4: v = 1;
          default: v = 32767;
        endcase
      end
    endcase
    return v[DATA_WIDTH-1:0];
  endfunction

  task automatic send_word(input cdiv_in_t w);
    bit taken;
    while (idle_on && $urandom_range(99) < 32) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    quot_expected.push_back(quotient_of(w));
    n_sent++;
  endtask

  // Sample before the edge, act after it; stall is redrawn every cycle.
  always begin : result_check
    cdiv_out_t got;
    cdiv_out_t want;
    bit        take;
    @(negedge clk);
    take = rst_n && out_valid && !out_stall;
    got = out_data;
    @(posedge clk);
    if (take) begin
      if (quot_expected.size() == 0) begin
        $display("%0t: result with nothing expected: %p", $time, got);
        errors++;
      end else begin
        want = quot_expected.pop_front();
        n_checked++;
        if (want.div_by_zero) n_zero_div++;
        if (want.saturated) n_clipped++;
        if (got.q_re !== want.q_re) begin
          $display("%0t: q_re expected %0d got %0d", $time, want.q_re, got.q_re);
          errors++;
        end
        if (got.q_im !== want.q_im) begin
          $display("%0t: q_im expected %0d got %0d", $time, want.q_im, got.q_im);
          errors++;
        end
        if (got.div_by_zero !== want.div_by_zero) begin
          $display("%0t: div_by_zero expected %b got %b", $time, want.div_by_zero,
                   got.div_by_zero);
          errors++;
        end
        if (got.saturated !== want.saturated) begin
          $display("%0t: saturated expected %b got %b", $time, want.saturated,
                   got.saturated);
          errors++;
        end
      end
    end
    out_stall <= idle_on && ($urandom_range(99) < 32);
  end

  task automatic test_plain_quotients();
    send_word(pack_word(256, 0, 256, 0));          // 1 / 1
    send_word(pack_word(0, 256, 0, 256));          // j / j
    send_word(pack_word(512, -768, 256, 256));     // mixed signs
    send_word(pack_word(-1, 0, 3, 0));             // truncate toward zero, negative
    send_word(pack_word(1, 0, -3, 0));
    send_word(pack_word(0, 0, -32768, 0));         // zero dividend
    send_word(pack_word(32767, -32768, -32768, -32768));
    send_word(pack_word(-32768, 32767, 32767, 32767));
    send_word(pack_word(1, 1, 0, 1));
    send_word(pack_word(-32768, 0, 256, 0));       // lands on the negative limit
    send_word(pack_word(32767, 0, 256, 0));        // lands on the positive limit
  endtask

  task automatic test_zero_divisor();
    send_word(pack_word(1234, -5, 0, 0));
    send_word(pack_word(-32768, 32767, 0, 0));
    send_word(pack_word(0, 0, 0, 0));
  endtask

  task automatic test_clipping();
    send_word(pack_word(32767, 32767, 1, 0));
    send_word(pack_word(-32768, -32768, 1, 0));
    send_word(pack_word(32767, 0, 255, 0));        // just past the positive limit
    send_word(pack_word(-32768, 0, 255, 0));       // just past the negative limit
    send_word(pack_word(-32768, -32768, 0, -1));
    send_word(pack_word(100, -100, -1, -1));
  endtask

  task automatic test_random_mix(int count);
    cdiv_in_t w;
    int unsigned kind;
    for (int i = 0; i < count; i++) begin
      // quiet stretch in the middle: no idling on either side
      idle_on = !(i >= count / 4 && i < count / 2);
      kind = $urandom_range(99);
      if (kind < 50) begin
        w.a_re = pick_part(0); w.a_im = pick_part(0);
        w.b_re = pick_part(0); w.b_im = pick_part(0);
      end else if (kind < 68) begin
        w.a_re = pick_part(0); w.a_im = pick_part(0);
        w.b_re = pick_part(1); w.b_im = pick_part(1);
      end else if (kind < 80) begin
        w.a_re = pick_part(1); w.a_im = pick_part(1);
        w.b_re = pick_part(0); w.b_im = pick_part(0);
      end else if (kind < 88) begin
        w.a_re = pick_part(0); w.a_im = pick_part(0);
        w.b_re = '0; w.b_im = '0;
      end else begin
        w.a_re = pick_part($urandom_range(2)); w.a_im = pick_part($urandom_range(2));
        w.b_re = pick_part($urandom_range(2)); w.b_im = pick_part($urandom_range(2));
      end
      send_word(w);
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_plain_quotients();
    test_zero_divisor();
    test_clipping();
    test_random_mix(400);
    in_valid <= 1'b0;
    while (quot_expected.size() != 0) @(posedge clk);
    // catch any stray word still in the pipe
    repeat (LATENCY + 10) @(posedge clk);
    $display("tb: %0d words sent, %0d results checked", n_sent, n_checked);
    $display("tb: %0d with zero divisor, %0d clipped to range", n_zero_div, n_clipped);
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
